// ----- hw/rtl/vgu_pkg.sv -----
// ----------------------------------------------------------------------------
// vgu_pkg
// Types, constants and rounding helpers for the 2D vector geometry unit.
// ----------------------------------------------------------------------------
package vgu_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;

	localparam logic [2:0] ACT_LEN    = 3'd0;
	localparam logic [2:0] ACT_LEN_SQ = 3'd1;
	localparam logic [2:0] ACT_NORM   = 3'd2;
	localparam logic [2:0] ACT_DIST   = 3'd3;
	localparam logic [2:0] ACT_LINE   = 3'd4;
	localparam logic [2:0] ACT_DOT    = 3'd5;

	// square root: 96-bit radicand, 48-bit root, one root bit per stage
	localparam int SQ_RAD_W  = 96;
	localparam int SQ_ROOT_W = 48;
	localparam int SQ_REM_W  = 50;
	localparam int SQ_STEPS  = 48;

	// normalize divide: quotient never exceeds 2^16, so 18 bits cover it
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 48;
	localparam int DIV_REM_W = 49;
	localparam int DIV_Q_W   = 18;

	localparam logic signed [67:0] WMAX68 = 68'sd2147483647;
	localparam logic signed [67:0] WMIN68 = -68'sd2147483648;
	localparam logic signed [67:0] RLIM68 = 68'sd4294967296;
	localparam logic [67:0] HALF68 = 68'd32768;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] scalar_out;
		logic signed [31:0] vec_x_out;
		logic signed [31:0] vec_y_out;
		logic               saturated;
	} out_req_t;

	// front-end context, stages 1 to 9
	typedef struct packed {
		logic [2:0]         action;
		logic               line;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] ddx;
		logic signed [31:0] ddy;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [66:0] sum;
		logic               npass;
		logic               nzero;
		logic signed [31:0] rval;
		logic               rsat;
	} ctx_t;

	// sideband carried alongside the square root and divide
	typedef struct packed {
		logic [2:0]         action;
		logic               line;
		logic               npass;
		logic               nzero;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] rval;
		logic               rsat;
		logic signed [31:0] lval;
		logic               lsat;
	} side_t;

	// shift right by the fraction width, round to nearest, ties away from zero
	function automatic logic signed [67:0] round_shift(input logic signed [67:0] a);
		logic [67:0] mag_v;
		logic [67:0] sh_v;
		mag_v = a[67] ? (~a + 68'd1) : a;
		sh_v = (mag_v + HALF68) >> FRAC_W;
		return a[67] ? (~sh_v + 68'd1) : sh_v;
	endfunction

	// clip to the word range; top bit is the clip flag
	function automatic logic [32:0] clamp_word(input logic signed [67:0] a);
		if (a > WMAX68)
			return {1'b1, WMAX68[31:0]};
		else if (a < WMIN68)
			return {1'b1, WMIN68[31:0]};
		else
			return {1'b0, a[31:0]};
	endfunction

	// residual clip to +-2^32
	function automatic logic signed [33:0] clamp_res(input logic signed [67:0] a);
		if (a > RLIM68)
			return RLIM68[33:0];
		else if (a < -RLIM68)
			return -RLIM68[33:0];
		else
			return a[33:0];
	endfunction

endpackage

// ----- hw/rtl/vector2d_geometry_unit.sv -----
// ----------------------------------------------------------------------------
// vector2d_geometry_unit
// Q16.16 2D vector unit: length, squared length, normalize, point and line
// distance, dot product, with saturation.
// Throughput: one request per cycle while the output buffer has room;
// depth is set by the 48-stage square root and 18-stage normalize divider.
// Reset clears all valid bits and the 2-entry output buffer; threshold is 0.
// ----------------------------------------------------------------------------
module vector2d_geometry_unit import vgu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  in_req_t     req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output out_req_t    rsp,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	logic [31:0] fuzz_q;
	logic [1:0]  cnt_q;
	logic        wr_ptr_q, rd_ptr_q;
	out_req_t    ent_q [2];
	logic        en, push, pop;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s59;
	logic [SQ_STEPS-1:0] v_sq;
	logic [DIV_Q_W-1:0]  v_dv;

	ctx_t ctx_c, ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9;
	ctx_t ctx3_c, ctx4_c, ctx5_c;
	logic signed [32:0] op0a_c, op0b_c, op1a_c, op1b_c;
	logic signed [32:0] op0a_s1, op0b_s1, op1a_s1, op1b_s1;
	logic signed [65:0] p0_s2, p1_s2;
	logic signed [67:0] rs_s4;
	logic signed [63:0] m0_s6, m1_s6;
	logic signed [67:0] r0_s7, r1_s7;
	logic signed [33:0] e0_s8, e1_s8;
	logic signed [67:0] q0_s9, q1_s9;
	logic [SQ_RAD_W-1:0] rad_c, rad_s10;
	side_t side_c, side_s10, side_s59, side_l59;
	side_t side_sq [SQ_STEPS];
	side_t side_dv [DIV_Q_W];

	logic [SQ_ROOT_W-1:0] root_sq;
	logic [SQ_REM_W-1:0]  rem_sq;
	logic [DIV_NUM_W-1:0] num0_c, num1_c, num0_s59, num1_s59;
	logic [DIV_DEN_W-1:0] den_s59;
	logic [DIV_Q_W-1:0]   quo0, quo1;
	out_req_t             out_c;

	logic signed [32:0] ax33, ay33, bx33, by33, dx33, dy33;
	logic               line_c;
	logic signed [66:0] sum_c3;
	logic [66:0]        s_u, diff_u;
	logic [32:0]        clamp_c;
	logic [65:0]        sq_c;
	logic [48:0]        len_rnd;
	logic [31:0]        max_ax, max_ay;
	logic [31:0]        nx_c, ny_c;
	side_t              sd;

	localparam logic [66:0] ONE_SQ = 67'd1 << (2 * FRAC_W);

	// flow control: pipeline advances while the output buffer has room
	assign en        = cnt_q != 2'd2;
	assign req_stall = !en;
	assign push      = en && v_dv[DIV_Q_W-1];
	assign pop       = rsp_valid && !rsp_stall;
	assign rsp_valid = cnt_q != 2'd0;
	assign rsp       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuzz_q <= '0;
		end else if (cfg_wr_en) begin
			fuzz_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_sq  <= '0;
			v_s59 <= 1'b0;
			v_dv  <= '0;
		end else if (en) begin
			v_s1  <= req_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_sq  <= {v_sq[SQ_STEPS-2:0], v_s10};
			v_s59 <= v_sq[SQ_STEPS-1];
			v_dv  <= {v_dv[DIV_Q_W-2:0], v_s59};
		end
	end

	// stage 1: differences and multiplier operand select
	always_comb begin
		ax33   = {req.a_x[31], req.a_x};
		ay33   = {req.a_y[31], req.a_y};
		bx33   = {req.b_x[31], req.b_x};
		by33   = {req.b_y[31], req.b_y};
		dx33   = ax33 - bx33;
		dy33   = ay33 - by33;
		line_c = (req.action == ACT_LINE) && ((req.dir_x != '0) || (req.dir_y != '0));
		ctx_c        = '0;
		ctx_c.action = req.action;
		ctx_c.line   = line_c;
		ctx_c.ax     = req.a_x;
		ctx_c.ay     = req.a_y;
		ctx_c.ddx    = req.dir_x;
		ctx_c.ddy    = req.dir_y;
		ctx_c.dx     = dx33;
		ctx_c.dy     = dy33;
		op0a_c = '0;
		op0b_c = '0;
		op1a_c = '0;
		op1b_c = '0;
		unique case (req.action)
			ACT_LEN, ACT_LEN_SQ, ACT_NORM: begin
				op0a_c = ax33;
				op0b_c = ax33;
				op1a_c = ay33;
				op1b_c = ay33;
			end
			ACT_DIST: begin
				op0a_c = dx33;
				op0b_c = dx33;
				op1a_c = dy33;
				op1b_c = dy33;
			end
			ACT_LINE: begin
				op0a_c = dx33;
				op1a_c = dy33;
				if (line_c) begin
					op0b_c = {req.dir_x[31], req.dir_x};
					op1b_c = {req.dir_y[31], req.dir_y};
				end else begin
					op0b_c = dx33;
					op1b_c = dy33;
				end
			end
			ACT_DOT: begin
				op0a_c = ax33;
				op0b_c = bx33;
				op1a_c = ay33;
				op1b_c = by33;
			end
			default: begin
				op0a_c = '0;
			end
		endcase
	end

	// stages 3 to 5 helpers
	always_comb begin
		sum_c3  = {p0_s2[65], p0_s2} + {p1_s2[65], p1_s2};
		s_u     = ctx_s3.sum;
		diff_u  = (s_u >= ONE_SQ) ? (s_u - ONE_SQ) : (ONE_SQ - s_u);
		clamp_c = clamp_word(rs_s4);

		ctx3_c     = ctx_s2;
		ctx3_c.sum = sum_c3;

		ctx4_c       = ctx_s3;
		ctx4_c.npass = diff_u <= {35'd0, fuzz_q};
		ctx4_c.nzero = s_u <= {35'd0, fuzz_q};

		ctx5_c      = ctx_s4;
		ctx5_c.rval = clamp_c[31:0];
		ctx5_c.rsat = clamp_c[32];
	end

	// stage 10: pick radicand
	always_comb begin
		sq_c = ctx_s9.line ? 66'(q0_s9 + q1_s9) : ctx_s9.sum[65:0];
		if (ctx_s9.action == ACT_NORM)
			rad_c = {ctx_s9.sum[63:0], 32'd0};
		else
			rad_c = {30'd0, sq_c};
		side_c        = '0;
		side_c.action = ctx_s9.action;
		side_c.line   = ctx_s9.line;
		side_c.npass  = ctx_s9.npass;
		side_c.nzero  = ctx_s9.nzero;
		side_c.ax     = ctx_s9.ax;
		side_c.ay     = ctx_s9.ay;
		side_c.rval   = ctx_s9.rval;
		side_c.rsat   = ctx_s9.rsat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1  <= ctx_c;
			op0a_s1 <= op0a_c;
			op0b_s1 <= op0b_c;
			op1a_s1 <= op1a_c;
			op1b_s1 <= op1b_c;

			ctx_s2 <= ctx_s1;
			p0_s2  <= op0a_s1 * op0b_s1;
			p1_s2  <= op1a_s1 * op1b_s1;

			ctx_s3 <= ctx3_c;

			ctx_s4 <= ctx4_c;
			rs_s4  <= round_shift({ctx_s3.sum[66], ctx_s3.sum});

			ctx_s5 <= ctx5_c;

			ctx_s6 <= ctx_s5;
			m0_s6  <= $signed(ctx_s5.rval) * $signed(ctx_s5.ddx);
			m1_s6  <= $signed(ctx_s5.rval) * $signed(ctx_s5.ddy);

			ctx_s7 <= ctx_s6;
			r0_s7  <= round_shift({{4{m0_s6[63]}}, m0_s6});
			r1_s7  <= round_shift({{4{m1_s6[63]}}, m1_s6});

			ctx_s8 <= ctx_s7;
			e0_s8  <= clamp_res({{35{ctx_s7.dx[32]}}, ctx_s7.dx} - r0_s7);
			e1_s8  <= clamp_res({{35{ctx_s7.dy[32]}}, ctx_s7.dy} - r1_s7);

			ctx_s9 <= ctx_s8;
			q0_s9  <= e0_s8 * e0_s8;
			q1_s9  <= e1_s8 * e1_s8;

			rad_s10  <= rad_c;
			side_s10 <= side_c;

			side_sq[0] <= side_s10;
			for (int i = 1; i < SQ_STEPS; i++)
				side_sq[i] <= side_sq[i-1];

			num0_s59 <= num0_c;
			num1_s59 <= num1_c;
			den_s59  <= root_sq;
			side_s59 <= side_l59;

			side_dv[0] <= side_s59;
			for (int i = 1; i < DIV_Q_W; i++)
				side_dv[i] <= side_dv[i-1];
		end
	end

	vgu_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s10),
		.root (root_sq),
		.rem  (rem_sq)
	);

	// after the root: round length, build divide numerators
	always_comb begin
		len_rnd = {1'b0, root_sq} + ((rem_sq > {2'b00, root_sq}) ? 49'd1 : 49'd0);
		side_l59 = side_sq[SQ_STEPS-1];
		if (len_rnd > 49'd2147483647) begin
			side_l59.lval = WMAX68[31:0];
			side_l59.lsat = 1'b1;
		end else begin
			side_l59.lval = len_rnd[31:0];
			side_l59.lsat = 1'b0;
		end
		max_ax = side_sq[SQ_STEPS-1].ax[31] ? (~side_sq[SQ_STEPS-1].ax + 32'd1)
			: side_sq[SQ_STEPS-1].ax;
		max_ay = side_sq[SQ_STEPS-1].ay[31] ? (~side_sq[SQ_STEPS-1].ay + 32'd1)
			: side_sq[SQ_STEPS-1].ay;
		num0_c = {max_ax, 32'd0} + {17'd0, root_sq[SQ_ROOT_W-1:1]};
		num1_c = {max_ay, 32'd0} + {17'd0, root_sq[SQ_ROOT_W-1:1]};
	end

	vgu_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (num0_s59),
		.den (den_s59),
		.quo (quo0)
	);

	vgu_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (num1_s59),
		.den (den_s59),
		.quo (quo1)
	);

	// result assembly
	always_comb begin
		sd    = side_dv[DIV_Q_W-1];
		nx_c  = sd.ax[31] ? (~{14'd0, quo0} + 32'd1) : {14'd0, quo0};
		ny_c  = sd.ay[31] ? (~{14'd0, quo1} + 32'd1) : {14'd0, quo1};
		out_c = '0;
		unique case (sd.action)
			ACT_LEN, ACT_DIST: begin
				out_c.scalar_out = sd.lval;
				out_c.saturated  = sd.lsat;
			end
			ACT_LINE: begin
				out_c.scalar_out = sd.lval;
				out_c.saturated  = sd.lsat || (sd.line && sd.rsat);
			end
			ACT_LEN_SQ, ACT_DOT: begin
				out_c.scalar_out = sd.rval;
				out_c.saturated  = sd.rsat;
			end
			ACT_NORM: begin
				if (sd.npass) begin
					out_c.vec_x_out = sd.ax;
					out_c.vec_y_out = sd.ay;
				end else if (!sd.nzero) begin
					out_c.vec_x_out = nx_c;
					out_c.vec_y_out = ny_c;
				end
			end
			default: begin
				out_c = '0;
			end
		endcase
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= out_c;
	end

endmodule

// ----- hw/rtl/vgu_sqrt.sv -----
// ----------------------------------------------------------------------------
// vgu_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vgu_sqrt import vgu_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQ_RAD_W-1:0]  rad,
	output logic [SQ_ROOT_W-1:0] root,
	output logic [SQ_REM_W-1:0]  rem
);

	logic [SQ_RAD_W-1:0]  rad_sn  [SQ_STEPS];
	logic [SQ_ROOT_W-1:0] root_sn [SQ_STEPS];
	logic [SQ_REM_W-1:0]  rem_sn  [SQ_STEPS];

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
		logic [SQ_RAD_W-1:0]  rad_in;
		logic [SQ_ROOT_W-1:0] root_in;
		logic [SQ_REM_W-1:0]  rem_in;
		logic [SQ_REM_W-1:0]  rem2;
		logic [SQ_REM_W-1:0]  trial;
		logic                 ge;

		if (g == 0) begin : g_first
			assign rad_in  = rad;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign rad_in  = rad_sn[g-1];
			assign root_in = root_sn[g-1];
			assign rem_in  = rem_sn[g-1];
		end

		assign rem2  = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sn[g]  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
				root_sn[g] <= {root_in[SQ_ROOT_W-2:0], ge};
				rem_sn[g]  <= ge ? (rem2 - trial) : rem2;
			end
		end
	end

	assign root = root_sn[SQ_STEPS-1];
	assign rem  = rem_sn[SQ_STEPS-1];

endmodule

// ----- hw/rtl/vgu_div.sv -----
// ----------------------------------------------------------------------------
// vgu_div
// Pipelined restoring divider, one quotient bit per stage, short quotient.
// ----------------------------------------------------------------------------
module vgu_div import vgu_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_Q_W-1:0]   quo
);

	localparam int DIV_STEPS_LOCAL = DIV_Q_W;

	logic [DIV_REM_W-1:0] rem_sn [DIV_STEPS_LOCAL];
	logic [DIV_Q_W-1:0]   low_sn [DIV_STEPS_LOCAL];
	logic [DIV_DEN_W-1:0] den_sn [DIV_STEPS_LOCAL];
	logic [DIV_Q_W-1:0]   quo_sn [DIV_STEPS_LOCAL];

	for (genvar g = 0; g < DIV_STEPS_LOCAL; g++) begin : g_step
		logic [DIV_REM_W-1:0] rem_in;
		logic [DIV_Q_W-1:0]   low_in;
		logic [DIV_DEN_W-1:0] den_in;
		logic [DIV_Q_W-1:0]   quo_in;
		logic [DIV_REM_W-1:0] rem2;
		logic                 ge;

		if (g == 0) begin : g_first
			// quotient fits in DIV_Q_W bits, so the top part is below den
			assign rem_in = {{(DIV_REM_W-DIV_NUM_W+DIV_Q_W){1'b0}},
				num[DIV_NUM_W-1:DIV_Q_W]};
			assign low_in = num[DIV_Q_W-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sn[g-1];
			assign low_in = low_sn[g-1];
			assign den_in = den_sn[g-1];
			assign quo_in = quo_sn[g-1];
		end

		assign rem2 = {rem_in[DIV_REM_W-2:0], low_in[DIV_Q_W-1]};
		assign ge   = rem2 >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[g] <= ge ? (rem2 - {1'b0, den_in}) : rem2;
				low_sn[g] <= {low_in[DIV_Q_W-2:0], 1'b0};
				den_sn[g] <= den_in;
				quo_sn[g] <= {quo_in[DIV_Q_W-2:0], ge};
			end
		end
	end

	assign quo = quo_sn[DIV_STEPS_LOCAL-1];

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// vector2d_geometry_unit testbench
// Directed and random requests through all six actions plus the unused codes.
// A scoreboard predicts each result in fixed point and compares it field by
// field. Random sender gaps, receiver stalls, one long hold-off and several
// threshold settings are covered.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vgu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic signed [127:0] W_MAX = 128'sd2147483647;
	localparam logic signed [127:0] W_MIN = -128'sd2147483648;
	localparam logic signed [127:0] RES_LIM = 128'sd4294967296;
	localparam logic signed [31:0] ONE_Q = 32'sd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	in_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_req_t rsp;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	vector2d_geometry_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] fuzz_thr = '0;
	out_req_t expected_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_sat = 0;
	int cycles = 0;
	int burst_left = 0;
	int hold_off = 0;
	int stall_mode = 0;

	// ---------------- fixed-point predictor ----------------
	function automatic logic [63:0] root_of(input logic [127:0] s, input bit rnd);
		logic [63:0] r;
		logic [127:0] c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = {64'd0, r | (64'd1 << i)};
			if (c * c <= s)
				r = c[63:0];
		end
		c = {64'd0, r};
		if (rnd && (s - c * c) > c)
			r = r + 64'd1;
		return r;
	endfunction

	function automatic logic signed [127:0] rnd_shift(input logic signed [127:0] a);
		logic [127:0] m;
		m = a[127] ? -a : a;
		m = (m + 128'd32768) >> FRAC_W;
		return a[127] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] clip_word(input logic signed [127:0] a,
			inout bit sat);
		if (a > W_MAX) begin
			sat = 1'b1;
			return W_MAX[31:0];
		end
		if (a < W_MIN) begin
			sat = 1'b1;
			return W_MIN[31:0];
		end
		return a[31:0];
	endfunction

	function automatic logic signed [31:0] length_q(input logic signed [127:0] x,
			input logic signed [127:0] y, inout bit sat);
		logic [63:0] r;
		r = root_of(x * x + y * y, 1'b1);
		if (r > 64'd2147483647) begin
			sat = 1'b1;
			return W_MAX[31:0];
		end
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] norm_comp(input logic signed [31:0] c,
			input logic [63:0] len, inout bit sat);
		logic [127:0] num;
		logic [127:0] q;
		logic signed [127:0] cw;
		cw = c;
		num = (cw[127] ? -cw : cw) << (2 * FRAC_W);
		q = (num + {64'd0, len >> 1}) / {64'd0, len};
		return clip_word(cw[127] ? -$signed(q) : $signed(q), sat);
	endfunction

	function automatic out_req_t predict_vector(input in_req_t it, input logic [31:0] thr);
		out_req_t o;
		bit sat;
		logic signed [127:0] ax, ay, bx, by, ddx, ddy, dx, dy, t, ex, ey;
		logic [127:0] s, diff, one, thr_w;
		logic [63:0] len;
		o = '0;
		sat = 1'b0;
		ax = it.a_x; ay = it.a_y; bx = it.b_x; by = it.b_y;
		ddx = it.dir_x; ddy = it.dir_y;
		dx = ax - bx; dy = ay - by;
		thr_w = {96'd0, thr};
		case (it.action)
			ACT_LEN: o.scalar_out = length_q(ax, ay, sat);
			ACT_LEN_SQ: o.scalar_out = clip_word(rnd_shift(ax * ax + ay * ay), sat);
			ACT_NORM: begin
				s = ax * ax + ay * ay;
				one = 128'd1 << (2 * FRAC_W);
				diff = (s >= one) ? s - one : one - s;
				if (diff <= thr_w) begin
					o.vec_x_out = it.a_x;
					o.vec_y_out = it.a_y;
				end else if (s > thr_w) begin
					len = root_of(s << 32, 1'b0);
					o.vec_x_out = norm_comp(it.a_x, len, sat);
					o.vec_y_out = norm_comp(it.a_y, len, sat);
				end
			end
			ACT_DIST: o.scalar_out = length_q(dx, dy, sat);
			ACT_LINE: begin
				if (ddx == 0 && ddy == 0) begin
					o.scalar_out = length_q(dx, dy, sat);
				end else begin
					t = clip_word(rnd_shift(dx * ddx + dy * ddy), sat);
					ex = dx - rnd_shift(t * ddx);
					ey = dy - rnd_shift(t * ddy);
					// residuals are clipped without touching the flag
					if (ex > RES_LIM) ex = RES_LIM;
					else if (ex < -RES_LIM) ex = -RES_LIM;
					if (ey > RES_LIM) ey = RES_LIM;
					else if (ey < -RES_LIM) ey = -RES_LIM;
					o.scalar_out = length_q(ex, ey, sat);
				end
			end
			ACT_DOT: o.scalar_out = clip_word(rnd_shift(ax * bx + ay * by), sat);
			default: ;
		endcase
		o.saturated = sat;
		return o;
	endfunction

	// ---------------- scoreboard ----------------
	always @(posedge clk) begin
		if (arst_n && cfg_wr_en)
			fuzz_thr <= cfg_wr_data;
		if (arst_n && req_valid && !req_stall)
			expected_q.push_back(predict_vector(req, fuzz_thr));
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("ERROR t=%0t %s: got %h expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		out_req_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing pending", rsp.scalar_out, 32'd0);
			end else begin
				e = expected_q.pop_front();
				n_checked++;
				if (e.saturated) n_sat++;
				if (rsp.scalar_out !== e.scalar_out)
					report_mismatch("scalar_out", rsp.scalar_out, e.scalar_out);
				if (rsp.vec_x_out !== e.vec_x_out)
					report_mismatch("vec_x_out", rsp.vec_x_out, e.vec_x_out);
				if (rsp.vec_y_out !== e.vec_y_out)
					report_mismatch("vec_y_out", rsp.vec_y_out, e.vec_y_out);
				if (rsp.saturated !== e.saturated)
					report_mismatch("saturated", {31'd0, rsp.saturated},
						{31'd0, e.saturated});
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(3) == 0);
				default: rsp_stall <= ((cycles % 7) < 4);
			endcase
		end
		if (cycles % 300 == 0)
			stall_mode <= $urandom_range(2);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles,
				expected_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic send_request(input in_req_t it, input bit gaps);
		int gap;
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
		if (gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 1);
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic idle_sender();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		idle_sender();
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_req_t mk(input logic [2:0] act, input logic [31:0] ax,
			input logic [31:0] ay, input logic [31:0] bx, input logic [31:0] by,
			input logic [31:0] dx, input logic [31:0] dy);
		in_req_t it;
		it.action = act; it.a_x = ax; it.a_y = ay; it.b_x = bx; it.b_y = by;
		it.dir_x = dx; it.dir_y = dy;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0, 1, 2: return $urandom();
			3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			4: return 32'd0;
			5: return $urandom_range(1) ? ONE_Q : -ONE_Q;
			default: return $signed($urandom_range(32'h40000)) - 32'sh20000;
		endcase
	endfunction

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return ONE_Q;
			2: return -ONE_Q;
			3: return 32'd46341;
			4: return $urandom();
			default: return $signed($urandom_range(32'h20000)) - 32'sh10000;
		endcase
	endfunction

	function automatic in_req_t rand_request();
		in_req_t it;
		it.action = ($urandom_range(40) == 0) ? 3'($urandom_range(7, 6))
			: 3'($urandom_range(5));
		it.a_x = rand_coord(); it.a_y = rand_coord();
		it.b_x = rand_coord(); it.b_y = rand_coord();
		it.dir_x = rand_dir(); it.dir_y = rand_dir();
		// bias some normalize requests toward unit length
		if (it.action == ACT_NORM && $urandom_range(3) == 0) begin
			it.a_x = ONE_Q + $signed($urandom_range(64)) - 32;
			it.a_y = $signed($urandom_range(64)) - 32;
		end
		return it;
	endfunction

	task automatic test_directed();
		logic [31:0] mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		write_threshold(32'd0);
		send_request(mk(ACT_LEN, mx, mx, 0, 0, 0, 0), 0);
		send_request(mk(ACT_LEN, mn, mn, 0, 0, 0, 0), 0);
		send_request(mk(ACT_LEN, 3 * ONE_Q, 4 * ONE_Q, 0, 0, 0, 0), 0);
		send_request(mk(ACT_LEN_SQ, mn, mn, 0, 0, 0, 0), 0);
		send_request(mk(ACT_LEN_SQ, 32'd1, 32'hffffffff, 0, 0, 0, 0), 0);
		send_request(mk(ACT_NORM, ONE_Q, 0, 0, 0, 0, 0), 0);
		send_request(mk(ACT_NORM, 0, 0, 0, 0, 0, 0), 0);
		send_request(mk(ACT_NORM, mn, mx, 0, 0, 0, 0), 0);
		send_request(mk(ACT_NORM, 32'd1, 32'd0, 0, 0, 0, 0), 0);
		send_request(mk(ACT_DIST, mx, mx, mn, mn, 0, 0), 0);
		send_request(mk(ACT_DIST, ONE_Q, 0, 0, ONE_Q, 0, 0), 0);
		send_request(mk(ACT_LINE, 5 * ONE_Q, 2 * ONE_Q, 0, 0, 0, 0), 0);
		send_request(mk(ACT_LINE, 5 * ONE_Q, 2 * ONE_Q, 0, 0, ONE_Q, 0), 0);
		send_request(mk(ACT_LINE, mx, mx, mn, mn, mx, mx), 0);
		send_request(mk(ACT_LINE, mx, mn, mn, mx, mn, mn), 0);
		send_request(mk(ACT_DOT, mx, mx, mx, mx, 0, 0), 0);
		send_request(mk(ACT_DOT, mn, mn, mx, mx, 0, 0), 0);
		send_request(mk(ACT_DOT, ONE_Q, -ONE_Q, ONE_Q, ONE_Q, 0, 0), 0);
		send_request(mk(3'd6, mx, mx, mx, mx, mx, mx), 0);
		send_request(mk(3'd7, mn, mn, mn, mn, mn, mn), 0);
		write_threshold(32'd4096);
		send_request(mk(ACT_NORM, ONE_Q, 32'd1, 0, 0, 0, 0), 0);
		send_request(mk(ACT_NORM, 32'd40, 32'd40, 0, 0, 0, 0), 0);
		write_threshold(32'hffffffff);
		send_request(mk(ACT_NORM, 32'd1000, 32'd0, 0, 0, 0, 0), 0);
		send_request(mk(ACT_NORM, 32'd70000, 32'd1000, 0, 0, 0, 0), 0);
		wait_drained();
	endtask

	task automatic test_random(input logic [31:0] thr, input int count);
		write_threshold(thr);
		repeat (count) send_request(rand_request(), 1);
		wait_drained();
	endtask

	// long receiver hold-off while requests keep coming: the pipe fills
	task automatic test_backpressure();
		hold_off = 500;
		repeat (150) send_request(rand_request(), 0);
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(32'd0, 500);
		test_random(32'd65536, 300);
		test_backpressure();
		test_random(32'hffffffff, 300);
		test_random($urandom(), 300);
		test_random(32'd0, 200);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over all actions and five threshold settings;",
			n_sent);
		$display("checked %0d results, %0d of them saturated.", n_checked, n_sat);
		if (errors == 0 && expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
